### sv/rmws_pkg.sv
// Shared types, codes and reset values for the radio module watchdog sequencer.
package rmws_pkg;

	localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd50;
	localparam logic [7:0] STUCK_SECONDS_RST = 8'd10;
	localparam logic [7:0] IDLE_MINUTES_RST = 8'd60;
	localparam logic [7:0] SETTLE_TICKS_RST = 8'd5;
	localparam logic SLEEP_GATE_RST = 1'b0;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;

	localparam int CFG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_TICKS_PER_SECOND = 3'd0,
		REG_STUCK_SECONDS = 3'd1,
		REG_IDLE_MINUTES = 3'd2,
		REG_SETTLE_TICKS = 3'd3,
		REG_SLEEP_GATE = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_IDLE = 3'd1,
		CMD_POWER_ON = 3'd2,
		CMD_POWER_OFF = 3'd3,
		CMD_RESTART = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ON = 4'b0010,
		ST_OFF = 4'b0100,
		ST_RESTART = 4'b1000
	} seq_t;

	typedef enum logic [1:0] {
		PHASE_IDLE = 2'd0,
		PHASE_ON = 2'd1,
		PHASE_OFF = 2'd2,
		PHASE_RESTART = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		PIN_LOW = 2'd0,
		PIN_FLOAT = 2'd1,
		PIN_UART = 2'd2
	} pin_t;

	typedef struct packed {
		logic [7:0] ticks_per_second;
		logic [7:0] stuck_seconds;
		logic [7:0] idle_minutes;
		logic [7:0] settle_ticks;
		logic sleep_gate_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] high_ticks;
		logic [7:0] high_secs;
		logic [7:0] low_ticks;
		logic [7:0] low_secs;
		logic [7:0] quiet_ticks;
		logic [5:0] quiet_secs;
		logic [7:0] quiet_mins;
		seq_t seq;
		logic [7:0] settle_count;
		logic init_mark;
		logic enable;
		pin_t pins;
	} state_t;

	localparam state_t STATE_RST = '{
		high_ticks: 8'd0,
		high_secs: 8'd0,
		low_ticks: 8'd0,
		low_secs: 8'd0,
		quiet_ticks: 8'd0,
		quiet_secs: 6'd0,
		quiet_mins: 8'd0,
		seq: ST_IDLE,
		settle_count: 8'd0,
		init_mark: 1'b0,
		enable: 1'b0,
		pins: PIN_LOW
	};

endpackage

### sv/rmws_step.sv
// Next-state logic for one tick: command, three watchdogs and one sequencer step.
module rmws_step (
	input  rmws_pkg::cfg_t   cfg,
	input  rmws_pkg::state_t cur,
	input  logic             status_level,
	input  logic             data_seen,
	input  logic [2:0]       command,
	input  logic             sleeping,
	output rmws_pkg::state_t nxt,
	output logic             fired
);
	import rmws_pkg::*;

	always_comb begin
		state_t s;
		logic fire;
		logic [7:0] t1;
		logic [7:0] s1;
		logic [7:0] m1;
		logic [8:0] cnt_inc;
		logic settle_done;

		s = cur;
		fire = 1'b0;
		m1 = 8'd0;

		case (cmd_t'(command))
			CMD_IDLE: begin
				s.seq = ST_IDLE;
				s.init_mark = 1'b1;
			end
			CMD_POWER_ON: begin
				s.seq = ST_ON;
				s.init_mark = 1'b1;
			end
			CMD_POWER_OFF: begin
				s.seq = ST_OFF;
				s.init_mark = 1'b1;
			end
			CMD_RESTART: begin
				s.seq = ST_RESTART;
				s.init_mark = 1'b1;
			end
			default: begin
			end
		endcase

		if (status_level) begin
			s.low_ticks = 8'd0;
			s.low_secs = 8'd0;
			t1 = cur.high_ticks + 8'd1;
			s1 = cur.high_secs + 8'd1;
			s.high_ticks = t1;
			if (t1 >= cfg.ticks_per_second) begin
				s.high_ticks = 8'd0;
				s.high_secs = s1;
				if (s1 >= cfg.stuck_seconds) begin
					s.high_secs = 8'd0;
					fire = 1'b1;
				end
			end
		end else begin
			s.high_ticks = 8'd0;
			s.high_secs = 8'd0;
			t1 = cur.low_ticks + 8'd1;
			s1 = cur.low_secs + 8'd1;
			s.low_ticks = t1;
			if (t1 >= cfg.ticks_per_second) begin
				s.low_ticks = 8'd0;
				s.low_secs = s1;
				if (s1 >= cfg.stuck_seconds) begin
					s.low_secs = 8'd0;
					fire = 1'b1;
				end
			end
		end

		if (data_seen) begin
			s.quiet_ticks = 8'd0;
			s.quiet_secs = 6'd0;
			s.quiet_mins = 8'd0;
		end
		s.quiet_ticks = s.quiet_ticks + 8'd1;
		if (s.quiet_ticks >= cfg.ticks_per_second) begin
			s.quiet_ticks = 8'd0;
			s.quiet_secs = s.quiet_secs + 6'd1;
			if (s.quiet_secs >= SECS_PER_MIN) begin
				s.quiet_secs = 6'd0;
				m1 = s.quiet_mins + 8'd1;
				s.quiet_mins = m1;
				if (m1 >= cfg.idle_minutes) begin
					s.quiet_mins = 8'd0;
					fire = 1'b1;
				end
			end
		end

		if (fire) begin
			s.seq = ST_RESTART;
			s.init_mark = 1'b1;
		end

		cnt_inc = 9'd0;
		settle_done = 1'b0;
		case (s.seq)
			ST_ON: begin
				if (s.init_mark) begin
					s.init_mark = 1'b0;
					s.settle_count = 8'd0;
					s.pins = PIN_FLOAT;
					s.enable = 1'b1;
				end
				cnt_inc = {1'b0, s.settle_count} + 9'd1;
				settle_done = cnt_inc > {1'b0, cfg.settle_ticks};
				if (settle_done) begin
					s.settle_count = 8'd0;
					s.seq = ST_IDLE;
					s.pins = PIN_UART;
				end else begin
					s.settle_count = cnt_inc[7:0];
				end
			end
			ST_OFF: begin
				s.init_mark = 1'b0;
				s.settle_count = 8'd0;
				s.enable = 1'b0;
				s.seq = ST_IDLE;
				s.pins = PIN_LOW;
			end
			ST_RESTART: begin
				if (!(cfg.sleep_gate_enable && sleeping)) begin
					if (s.init_mark) begin
						s.init_mark = 1'b0;
						s.settle_count = 8'd0;
						s.enable = 1'b0;
						s.pins = PIN_LOW;
					end
					cnt_inc = {1'b0, s.settle_count} + 9'd1;
					settle_done = cnt_inc > {1'b0, cfg.settle_ticks};
					if (settle_done) begin
						s.settle_count = 8'd0;
						s.seq = ST_ON;
						s.init_mark = 1'b1;
					end else begin
						s.settle_count = cnt_inc[7:0];
					end
				end
			end
			default: begin
			end
		endcase

		nxt = s;
		fired = fire;
	end

endmodule

### sv/radio_module_watchdog_sequencer_core.sv
// Top level of the radio module watchdog and power sequencer with its register port.
// Each input beat is one periodic tick; the block returns exactly one result beat per tick,
// registered in the cycle after the tick is taken, and accepts a new tick in every cycle
// while the result register is empty or being drained. All timers and the sequencer update
// together, so the sustained rate is one tick per clock, limited only by the downstream side.
// Registers sit at byte offsets 0x00 ticks_per_second, 0x04 stuck_seconds, 0x08 idle_minutes,
// 0x0C settle_ticks and 0x10 sleep_gate_enable, and should be written only while idle.
module radio_module_watchdog_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rmws_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            status_level,
	input  logic                            data_seen,
	input  logic [2:0]                      command,
	input  logic                            sleeping,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      phase,
	output logic                            module_enable,
	output logic [1:0]                      pin_mode,
	output logic                            restart_fired
);
	import rmws_pkg::*;

	cfg_t cfg_q;
	state_t st_q;
	state_t st_d;
	logic fired_d;
	logic accept;
	reg_idx_t reg_idx;
	logic out_valid_q;
	phase_t phase_q;
	logic enable_q;
	pin_t pins_q;
	logic fired_q;
	phase_t phase_d;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= TICKS_PER_SECOND_RST;
			cfg_q.stuck_seconds <= STUCK_SECONDS_RST;
			cfg_q.idle_minutes <= IDLE_MINUTES_RST;
			cfg_q.settle_ticks <= SETTLE_TICKS_RST;
			cfg_q.sleep_gate_enable <= SLEEP_GATE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= pwdata[7:0];
				REG_STUCK_SECONDS: cfg_q.stuck_seconds <= pwdata[7:0];
				REG_IDLE_MINUTES: cfg_q.idle_minutes <= pwdata[7:0];
				REG_SETTLE_TICKS: cfg_q.settle_ticks <= pwdata[7:0];
				REG_SLEEP_GATE: cfg_q.sleep_gate_enable <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TICKS_PER_SECOND: prdata = {24'd0, cfg_q.ticks_per_second};
			REG_STUCK_SECONDS: prdata = {24'd0, cfg_q.stuck_seconds};
			REG_IDLE_MINUTES: prdata = {24'd0, cfg_q.idle_minutes};
			REG_SETTLE_TICKS: prdata = {24'd0, cfg_q.settle_ticks};
			REG_SLEEP_GATE: prdata = {31'd0, cfg_q.sleep_gate_enable};
			default: prdata = 32'd0;
		endcase
	end

	rmws_step u_step (
		.cfg(cfg_q),
		.cur(st_q),
		.status_level(status_level),
		.data_seen(data_seen),
		.command(command),
		.sleeping(sleeping),
		.nxt(st_d),
		.fired(fired_d)
	);

	always_comb begin
		case (st_d.seq)
			ST_IDLE: phase_d = PHASE_IDLE;
			ST_ON: phase_d = PHASE_ON;
			ST_OFF: phase_d = PHASE_OFF;
			ST_RESTART: phase_d = PHASE_RESTART;
			default: phase_d = PHASE_IDLE;
		endcase
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q <= st_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_q <= phase_d;
			enable_q <= st_d.enable;
			pins_q <= st_d.pins;
			fired_q <= fired_d;
		end
	end

	assign out_valid = out_valid_q;
	assign phase = phase_q;
	assign module_enable = enable_q;
	assign pin_mode = pins_q;
	assign restart_fired = fired_q;

	// The enable line is high exactly when the link pins are not driven low.
	a_enable_pins: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.enable == (st_q.pins != PIN_LOW))
		else $error("enable and pin mode disagree");

	// A watchdog restart leaves the sequencer in restart, or in power-on when settling is instant.
	a_fired_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fired_q) |-> (phase_q == PHASE_RESTART || phase_q == PHASE_ON))
		else $error("restart fired without restart or power-on phase");

	// Every accepted tick produces a result beat in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted tick produced no result");

	a_pins_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pins == PIN_LOW || st_q.pins == PIN_FLOAT || st_q.pins == PIN_UART)
		else $error("illegal pin mode");

endmodule
